// ===== sv/ipv4ape_pkg.sv =====
// Package: shared types, character codes and scan-step functions of the IPv4 address extractor.
package ipv4ape_pkg;

    localparam logic [7:0]  CHAR_ZERO        = 8'h30;
    localparam logic [7:0]  CHAR_NINE        = 8'h39;
    localparam logic [7:0]  CHAR_DOT         = 8'h2E;
    localparam logic [7:0]  CHAR_COLON       = 8'h3A;
    localparam logic [19:0] OCTET_MAX        = 20'd255;
    localparam logic [19:0] PORT_MAX         = 20'd65535;
    localparam logic [2:0]  OCTET_DIGITS     = 3'd3;
    localparam logic [2:0]  PORT_DIGITS      = 3'd5;
    localparam logic [2:0]  PHASE_LAST_OCTET = 3'd3;
    localparam logic [2:0]  PHASE_PORT       = 3'd4;
    localparam int          OUT_TDATA_W      = 56;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_word;

    typedef struct packed {
        logic        found;
        logic [31:0] address;
        logic        has_port;
        logic [15:0] port;
    } t_result;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  dcnt;
        logic [16:0] value;
        logic        fzero;
        logic        in_token;
        logic        broken;
        logic [23:0] octets;
        logic        matched;
        logic [31:0] haddr;
        logic        hpv;
        logic [15:0] hport;
    } t_scan;

    function automatic t_scan clear_token(t_scan s);
        t_scan t;
        t          = s;
        t.phase    = '0;
        t.dcnt     = '0;
        t.value    = '0;
        t.fzero    = 1'b0;
        t.in_token = 1'b0;
        t.broken   = 1'b0;
        t.octets   = '0;
        return t;
    endfunction

    function automatic t_scan close_token(t_scan s);
        t_scan t;
        t = s;
        if (!t.broken && t.dcnt != 3'd0) begin
            if (t.phase == PHASE_LAST_OCTET) begin
                t.haddr   = {t.octets, t.value[7:0]};
                t.hpv     = 1'b0;
                t.hport   = '0;
                t.matched = 1'b1;
            end else if (t.phase == PHASE_PORT) begin
                t.hport   = t.value[15:0];
                t.hpv     = 1'b1;
                t.matched = 1'b1;
            end
        end
        return clear_token(t);
    endfunction

    function automatic t_scan take_byte(t_scan s, logic [7:0] c);
        t_scan       t;
        logic        dig;
        logic [2:0]  maxd;
        logic [19:0] lim;
        logic [19:0] v;
        t    = s;
        dig  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        if (!t.in_token) begin
            t = clear_token(t);
        end
        t.in_token = 1'b1;
        maxd = (t.phase == PHASE_PORT) ? PORT_DIGITS : OCTET_DIGITS;
        lim  = (t.phase == PHASE_PORT) ? PORT_MAX : OCTET_MAX;
        v    = {3'b000, t.value} * 20'd10 + {16'h0000, c[3:0]};
        if (!t.broken) begin
            if (dig) begin
                if (t.dcnt >= maxd || (t.dcnt != 3'd0 && t.fzero)) begin
                    t.broken = 1'b1;
                end else begin
                    if (t.dcnt == 3'd0) begin
                        t.fzero = (c == CHAR_ZERO);
                    end
                    t.value = v[16:0];
                    t.dcnt  = t.dcnt + 3'd1;
                    if (v > lim) begin
                        t.broken = 1'b1;
                    end
                end
            end else if (c == CHAR_DOT) begin
                if (t.phase < PHASE_LAST_OCTET && t.dcnt != 3'd0) begin
                    t.octets = {t.octets[15:0], t.value[7:0]};
                    t.phase  = t.phase + 3'd1;
                    t.dcnt   = '0;
                    t.value  = '0;
                    t.fzero  = 1'b0;
                end else begin
                    t.broken = 1'b1;
                end
            end else begin
                if (t.phase == PHASE_LAST_OCTET && t.dcnt != 3'd0) begin
                    t.haddr = {t.octets, t.value[7:0]};
                    t.phase = PHASE_PORT;
                    t.dcnt  = '0;
                    t.value = '0;
                    t.fzero = 1'b0;
                end else begin
                    t.broken = 1'b1;
                end
            end
        end
        return t;
    endfunction

endpackage

// ===== sv/ipv4_address_port_extractor.sv =====
// Top level: finds the first dotted-quad IPv4 address with optional port in a byte stream.
//
//   channel  dir  tdata fields (low bit up)                          tlast
//   s_axis   in   text_byte[7:0]                                     last_byte
//   m_axis   out  found, address[31:0], has_port, port[15:0], pad    -
//
// One text word is taken per cycle while no last word waits (see below); each word is
// registered, scanned by a single level of compare and multiply-by-ten logic, and the state
// updated when it is taken. A result is formed as its last word is taken, then registered.
// Reset (i_rst_n low, synchronous) empties both registers and clears scan state.
// A last word waits in the input register while an earlier result is unclaimed;
// other words keep flowing.
module ipv4_address_port_extractor
    import ipv4ape_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // text_byte[7:0]
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // found, address, has_port, port, zeros
);

    t_word   in_word;
    t_word   held_word;
    logic    held_valid;
    logic    take;
    logic    out_ready;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_word.text_byte = s_axis_tdata;
    assign in_word.last_byte = s_axis_tlast;

    ipv4ape_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (in_word),
        .o_valid (held_valid),
        .o_word  (held_word),
        .i_take  (take)
    );

    ipv4ape_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_word      (held_word),
        .i_out_ready (out_ready),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ipv4ape_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {6'b000000, out_res.port, out_res.has_port,
                           out_res.address, out_res.found};

endmodule

// ===== sv/ipv4ape_in_reg.sv =====
// Input register: holds one incoming text word until the scanner takes it.
module ipv4ape_in_reg
    import ipv4ape_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word,
    input  logic  i_take
);

    logic  r_valid;
    t_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

`ifndef SYNTHESIS
    a_take_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_valid)
        else $error("take without a held word");
    a_held_word_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |=> (r_valid && $stable(r_word)))
        else $error("held word lost before take");
`endif

endmodule

// ===== sv/ipv4ape_scan.sv =====
// Scanner: token state, per-word update and result forming on the last word.
module ipv4ape_scan
    import ipv4ape_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_word   i_word,
    input  logic    i_out_ready,
    output logic    o_take,
    output logic    o_res_valid,
    output t_result o_res
);

    t_scan r_scan;
    t_scan n_scan;
    t_scan s_step;
    logic  tok;

    assign o_take      = i_valid && (!i_word.last_byte || i_out_ready);
    assign o_res_valid = o_take && i_word.last_byte;

    always_comb begin
        tok = ((i_word.text_byte >= CHAR_ZERO) && (i_word.text_byte <= CHAR_NINE))
              || (i_word.text_byte == CHAR_DOT) || (i_word.text_byte == CHAR_COLON);
        s_step = r_scan;
        if (!r_scan.matched) begin
            if (tok) begin
                s_step = take_byte(s_step, i_word.text_byte);
            end else if (s_step.in_token) begin
                s_step = close_token(s_step);
            end
            if (i_word.last_byte && s_step.in_token && !s_step.matched) begin
                s_step = close_token(s_step);
            end
        end
        o_res.found    = s_step.matched;
        o_res.address  = s_step.matched ? s_step.haddr : 32'h0;
        o_res.has_port = s_step.matched && s_step.hpv;
        o_res.port     = (s_step.matched && s_step.hpv) ? s_step.hport : 16'h0;
        if (!o_take) begin
            n_scan = r_scan;
        end else if (i_word.last_byte) begin
            n_scan = '0;
        end else begin
            n_scan = s_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_word.last_byte) |=> (!r_scan.matched && !r_scan.in_token))
        else $error("state not cleared after last word");
    a_match_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan.matched && !(o_take && i_word.last_byte)) |=> r_scan.matched)
        else $error("latched match lost mid-string");
`endif

endmodule

// ===== sv/ipv4ape_out_reg.sv =====
// Output register: holds one result word until the downstream side takes it.
module ipv4ape_out_reg
    import ipv4ape_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

`ifndef SYNTHESIS
    a_empty_when_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.found) |-> (r_res.address == 32'h0 && !r_res.has_port
                                       && r_res.port == 16'h0))
        else $error("not-found result carries data");
    a_no_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.has_port) |-> (r_res.port == 16'h0))
        else $error("port set without has_port");
`endif

endmodule
